FILE: rtl/bfnb_pkg.sv
package bfnb_pkg;

	localparam int POS_W   = 10;
	localparam int USED_W  = 8;
	localparam int OP_W    = 3;
	localparam int WORD_W  = 64;
	localparam int WORD_LW = 6;

	localparam logic [USED_W-1:0] USED_RESET = 8'd128;

	localparam logic [OP_W-1:0] OP_CLEAR_USED = 3'd0;
	localparam logic [OP_W-1:0] OP_SET        = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
	localparam logic [OP_W-1:0] OP_TEST       = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND_FREE  = 3'd4;
	localparam logic [OP_W-1:0] OP_FIND_OCC   = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] found_index;
	} rsp_t;

	// word unit status back to the sequencer
	typedef struct packed {
		logic               found;
		logic [WORD_LW-1:0] found_bit;
		logic               bit_val;
	} wu_stat_t;

endpackage

FILE: rtl/bfnb_mem.sv
module bfnb_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/bfnb_word_unit.sv
module bfnb_word_unit #(
	parameter int AW    = 4,
	parameter int LIM_W = 11
) (
	input  logic [bfnb_pkg::OP_W-1:0]    op,
	input  logic [bfnb_pkg::WORD_W-1:0]  data,
	input  logic [AW-1:0]                word_idx,
	input  logic [bfnb_pkg::WORD_LW-1:0] start_bit,
	input  logic [bfnb_pkg::WORD_LW-1:0] bit_sel,
	input  logic [LIM_W-1:0]             limit,
	output logic [bfnb_pkg::WORD_W-1:0]  new_word,
	output bfnb_pkg::wu_stat_t           stat
);

	localparam int EXT_W = AW + bfnb_pkg::WORD_LW + 1;

	logic [EXT_W-1:0]               base_ext;
	logic [EXT_W-1:0]               lim_ext;
	logic [EXT_W-1:0]               span;
	logic [bfnb_pkg::WORD_W-1:0]    hi_mask;
	logic [bfnb_pkg::WORD_W-1:0]    lo_mask;
	logic [bfnb_pkg::WORD_W-1:0]    range_mask;
	logic [bfnb_pkg::WORD_W-1:0]    match;
	logic [bfnb_pkg::WORD_W-1:0]    onehot;
	logic                           want_one;
	logic [bfnb_pkg::WORD_LW-1:0]   low_bit;

	assign base_ext = EXT_W'({word_idx, {bfnb_pkg::WORD_LW{1'b0}}});
	assign lim_ext  = EXT_W'(limit);
	assign span     = lim_ext - base_ext;

	always_comb begin
		if (span >= EXT_W'(bfnb_pkg::WORD_W)) begin
			hi_mask = '1;
		end else begin
			hi_mask = ({{(bfnb_pkg::WORD_W-1){1'b0}}, 1'b1} << span[bfnb_pkg::WORD_LW-1:0])
				- {{(bfnb_pkg::WORD_W-1){1'b0}}, 1'b1};
		end
	end

	assign lo_mask    = {bfnb_pkg::WORD_W{1'b1}} << start_bit;
	assign range_mask = lo_mask & hi_mask;
	assign want_one   = (op == bfnb_pkg::OP_FIND_OCC);
	assign match      = (want_one ? data : ~data) & range_mask;
	assign onehot     = {{(bfnb_pkg::WORD_W-1){1'b0}}, 1'b1} << bit_sel;

	// lowest set bit of the match vector
	always_comb begin
		low_bit = '0;
		for (int i = bfnb_pkg::WORD_W - 1; i >= 0; i--) begin
			if (match[i]) begin
				low_bit = bfnb_pkg::WORD_LW'(i);
			end
		end
	end

	assign stat = {|match, low_bit, data[bit_sel]};

	always_comb begin
		case (op)
			bfnb_pkg::OP_CLEAR_USED: new_word = data & ~range_mask;
			bfnb_pkg::OP_SET:        new_word = data | onehot;
			bfnb_pkg::OP_CLEAR:      new_word = data & ~onehot;
			default:                 new_word = data;
		endcase
	end

endmodule

FILE: rtl/bitmap_find_next_bit.sv
// channel | dir | signals                         | payload
// req     | in  | req_valid, req_ready            | bfnb_pkg::req_t (op, position)
// rsp     | out | rsp_valid, rsp_ready            | bfnb_pkg::rsp_t (hit, found_index)
// cfg     | in  | cfg_wr_en                       | cfg_wr_data = used_bytes
//
// One request at a time; 64-bit words go through one word unit, one word per cycle.
// Set, clear, test: the word is read on accept, then written or tested. Search: scans from
// the word holding the position up to the last used word, stopping at a hit. Clear used bytes: words 0 to last used.
// After reset the store is swept to zero word by word, with req_ready low.
// The result register frees the input side; a result that finds it full waits.
module bitmap_find_next_bit #(
	parameter int NUM_BITS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bfnb_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bfnb_pkg::rsp_t                rsp,
	input  logic                          cfg_wr_en,
	input  logic [bfnb_pkg::USED_W-1:0]   cfg_wr_data
);

	localparam int NUM_WORDS = (NUM_BITS + bfnb_pkg::WORD_W - 1) / bfnb_pkg::WORD_W;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LIM_W     = $clog2(NUM_BITS + 1);
	localparam int RAW_W     = bfnb_pkg::USED_W + 3;
	localparam int RW        = (LIM_W > RAW_W) ? LIM_W : RAW_W;
	localparam int CW        = (LIM_W > bfnb_pkg::POS_W) ? LIM_W : bfnb_pkg::POS_W;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [bfnb_pkg::USED_W-1:0]    used_q;
	logic [bfnb_pkg::OP_W-1:0]      op_q;
	logic [bfnb_pkg::POS_W-1:0]     pos_q;
	logic [LIM_W-1:0]               lim_q;
	logic [AW-1:0]                  cur_q;
	logic [AW-1:0]                  last_q;
	logic                           first_q;
	logic                           res_hit_q;
	logic [bfnb_pkg::POS_W-1:0]     res_idx_q;
	logic                           rsp_valid_q;
	bfnb_pkg::rsp_t                 rsp_q;

	logic                           req_fire;
	logic [RW-1:0]                  raw_lim;
	logic [LIM_W-1:0]               lim_now;
	logic [LIM_W-1:0]               lim_m1;
	logic [CW-1:0]                  pos_ext;
	logic                           pos_in_store;
	logic                           pos_in_lim;
	logic                           start_run;
	logic [AW-1:0]                  start_word;
	logic                           is_search_q;
	logic                           last_word;
	logic                           rsp_free;

	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [bfnb_pkg::WORD_W-1:0]    mem_wdata;
	logic                           mem_re;
	logic [AW-1:0]                  mem_raddr;
	logic [bfnb_pkg::WORD_W-1:0]    mem_rdata;

	logic [bfnb_pkg::WORD_W-1:0]    wu_word;
	bfnb_pkg::wu_stat_t             wu_stat;
	logic [bfnb_pkg::WORD_LW-1:0]   wu_start;
	logic [bfnb_pkg::POS_W-1:0]     hit_index;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// used length in bits, capped at the store size
	assign raw_lim = RW'({used_q, 3'b000});
	assign lim_now = (raw_lim > RW'(NUM_BITS)) ? LIM_W'(NUM_BITS) : LIM_W'(raw_lim);
	assign lim_m1  = lim_now - LIM_W'(1);

	assign pos_ext      = CW'(req.position);
	assign pos_in_store = pos_ext < CW'(NUM_BITS);
	assign pos_in_lim   = pos_ext < CW'(lim_now);

	always_comb begin
		case (req.op)
			bfnb_pkg::OP_SET,
			bfnb_pkg::OP_CLEAR,
			bfnb_pkg::OP_TEST:       start_run = pos_in_store;
			bfnb_pkg::OP_CLEAR_USED: start_run = (lim_now != '0);
			bfnb_pkg::OP_FIND_FREE,
			bfnb_pkg::OP_FIND_OCC:   start_run = pos_in_lim;
			default:                 start_run = 1'b0;
		endcase
	end

	assign start_word = (req.op == bfnb_pkg::OP_CLEAR_USED) ? '0
		: AW'(req.position >> bfnb_pkg::WORD_LW);

	assign is_search_q = (op_q == bfnb_pkg::OP_FIND_FREE) || (op_q == bfnb_pkg::OP_FIND_OCC);
	assign last_word   = (cur_q == last_q);
	assign wu_start    = first_q ? pos_q[bfnb_pkg::WORD_LW-1:0] : '0;
	assign hit_index   = bfnb_pkg::POS_W'({cur_q, wu_stat.found_bit});

	// memory ports
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = start_word;
		if (state_q == S_IDLE) begin
			mem_re    = req_fire && start_run;
			mem_raddr = start_word;
		end else if (state_q == S_RUN) begin
			mem_raddr = cur_q + AW'(1);
			mem_re    = !last_word && ((is_search_q && !wu_stat.found)
				|| (op_q == bfnb_pkg::OP_CLEAR_USED));
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = wu_word;
		if (state_q == S_INIT) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (state_q == S_RUN) begin
			mem_we = (op_q == bfnb_pkg::OP_SET) || (op_q == bfnb_pkg::OP_CLEAR)
				|| (op_q == bfnb_pkg::OP_CLEAR_USED);
		end
	end

	bfnb_mem #(
		.DEPTH (NUM_WORDS),
		.AW    (AW),
		.DW    (bfnb_pkg::WORD_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bfnb_word_unit #(
		.AW    (AW),
		.LIM_W (LIM_W)
	) u_word_unit (
		.op        (op_q),
		.data      (mem_rdata),
		.word_idx  (cur_q),
		.start_bit (wu_start),
		.bit_sel   (pos_q[bfnb_pkg::WORD_LW-1:0]),
		.limit     (lim_q),
		.new_word  (wu_word),
		.stat      (wu_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= bfnb_pkg::USED_RESET;
		end else if (cfg_wr_en) begin
			used_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (cur_q == AW'(NUM_WORDS - 1)) begin
						cur_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						op_q      <= req.op;
						pos_q     <= req.position;
						lim_q     <= lim_now;
						last_q    <= AW'(lim_m1 >> bfnb_pkg::WORD_LW);
						cur_q     <= start_word;
						first_q   <= (req.op == bfnb_pkg::OP_FIND_FREE)
							|| (req.op == bfnb_pkg::OP_FIND_OCC);
						res_hit_q <= 1'b0;
						res_idx_q <= '0;
						state_q   <= start_run ? S_RUN : S_DONE;
					end
				end
				S_RUN: begin
					case (op_q)
						bfnb_pkg::OP_TEST: begin
							res_hit_q <= wu_stat.bit_val;
							state_q   <= S_DONE;
						end
						bfnb_pkg::OP_FIND_FREE,
						bfnb_pkg::OP_FIND_OCC: begin
							first_q <= 1'b0;
							if (wu_stat.found) begin
								res_hit_q <= 1'b1;
								res_idx_q <= hit_index;
								state_q   <= S_DONE;
							end else if (last_word) begin
								state_q <= S_DONE;
							end else begin
								cur_q <= cur_q + AW'(1);
							end
						end
						bfnb_pkg::OP_CLEAR_USED: begin
							if (last_word) begin
								state_q <= S_DONE;
							end else begin
								cur_q <= cur_q + AW'(1);
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q   <= {res_hit_q, res_idx_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("store written while idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken while busy");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && is_search_q && wu_stat.found)
			|-> (CW'(hit_index) >= CW'(pos_q) && CW'(hit_index) < CW'(lim_q)))
		else $error("search hit outside start and used length");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && (is_search_q || op_q == bfnb_pkg::OP_CLEAR_USED))
			|-> (cur_q <= last_q))
		else $error("scan ran past last used word");
`endif

endmodule
